// ===== hw/rtl/ccfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Coil command frame driver package
// Shared widths, register defaults, codes and the types passed between the
// frame parser in the top level and the pulse sequencer.
// ----------------------------------------------------------------------------
package ccfd_pkg;

    // Field widths.
    localparam int BYTE_W    = 8;
    localparam int TIMEOUT_W = 10;
    localparam int TICK_W    = 8;
    localparam int FIELD_W   = 9;
    localparam int LEVEL_W   = 18;
    localparam int STATUS_W  = 3;
    localparam int COIL_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;

    // Coils whose two lines fit in the level word.
    localparam int LEVEL_COILS = LEVEL_W / 2;

    // Default coil count.
    localparam int COILS_DEF = 9;

    // Register reset values.
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 10'd100;
    localparam logic [TICK_W-1:0]    PAUSE_RST   = 8'd10;
    localparam logic [TICK_W-1:0]    DRIVE_RST   = 8'd15;
    localparam logic [BYTE_W-1:0]    HDR1_RST    = 8'hAA;
    localparam logic [BYTE_W-1:0]    HDR2_RST    = 8'h55;
    localparam logic [BYTE_W-1:0]    OFFSET_RST  = 8'h0A;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT = 3'd0,
        CFG_PAUSE   = 3'd1,
        CFG_DRIVE   = 3'd2,
        CFG_HDR1    = 3'd3,
        CFG_HDR2    = 3'd4,
        CFG_OFFSET  = 3'd5
    } t_cfg_idx;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_NONE       = 3'd0,
        ST_ACCEPTED   = 3'd1,
        ST_BAD_ID     = 3'd2,
        ST_BAD_ACTION = 3'd3,
        ST_TIMEOUT    = 3'd4,
        ST_BUSY_DROP  = 3'd5
    } t_status;

    // Input operation codes.
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    // Frame match position.
    typedef enum logic [3:0] {
        FP_HUNT = 4'b0001,
        FP_HDR1 = 4'b0010,
        FP_HDR2 = 4'b0100,
        FP_ID   = 4'b1000
    } t_frame_pos;

    // Pulse phase.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PAUSE = 3'b010,
        PH_DRIVE = 3'b100
    } t_phase;

    // Parser to sequencer control for one beat.
    typedef struct packed {
        logic              step;
        logic              tick;
        logic              start;
        logic [COIL_W-1:0] coil;
        logic              dir;
    } t_pulse_ctl;

    // Sequencer status back to the parser and output stage.
    typedef struct packed {
        logic               busy;
        logic               busy_nxt;
        logic [LEVEL_W-1:0] levels_nxt;
    } t_pulse_stat;

endpackage

// ===== hw/rtl/ccfd_if.sv =====
// ----------------------------------------------------------------------------
// Coil command frame driver channels
// Valid/ready channels for input beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface ccfd_in_if import ccfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface ccfd_out_if import ccfd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [LEVEL_W-1:0]        coil_levels;
    logic [STATUS_W-1:0]       status;
    logic signed [FIELD_W-1:0] frame_id;
    logic signed [FIELD_W-1:0] frame_action;
    logic                      busy_res;

    modport source (output valid, output coil_levels, output status, output frame_id,
                    output frame_action, output busy_res, input ready);
    modport sink   (input valid, input coil_levels, input status, input frame_id,
                    input frame_action, input busy_res, output ready);
endinterface

interface ccfd_cfg_if import ccfd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/ccfd_pulse.sv =====
// ----------------------------------------------------------------------------
// Coil pulse sequencer
// Runs the pause and drive phases of one coil pulse on tick beats and gives
// the line levels and busy flag that follow the current beat.
// ----------------------------------------------------------------------------
module ccfd_pulse
    import ccfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pulse_ctl        i_ctl,
    input  logic [TICK_W-1:0] i_pause_ticks,
    input  logic [TICK_W-1:0] i_drive_ticks,
    output t_pulse_stat       o_stat
);

    t_phase              r_phase, n_phase;
    logic [TICK_W-1:0]   r_cnt, n_cnt;
    logic [COIL_W-1:0]   r_coil, n_coil;
    logic                r_dir, n_dir;
    logic [TICK_W-1:0]   w_cnt_inc;
    logic [LEVEL_W-1:0]  w_levels;

    assign w_cnt_inc = r_cnt + 1'b1;

    // Phase sequencing: a start loads a new pulse, a tick advances it.
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_coil  = r_coil;
        n_dir   = r_dir;
        if (i_ctl.step && i_ctl.start) begin
            n_coil  = i_ctl.coil;
            n_dir   = i_ctl.dir;
            n_cnt   = '0;
            n_phase = (i_pause_ticks == '0) ? PH_DRIVE : PH_PAUSE;
        end else if (i_ctl.step && i_ctl.tick) begin
            case (r_phase)
                PH_PAUSE: begin
                    if (w_cnt_inc >= i_pause_ticks) begin
                        n_phase = PH_DRIVE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = w_cnt_inc;
                    end
                end
                PH_DRIVE: begin
                    if (w_cnt_inc >= i_drive_ticks) begin
                        n_phase = PH_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = w_cnt_inc;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_cnt   = '0;
                end
            endcase
        end
    end

    // Line levels after this beat: action 1 drives the first line.
    always_comb begin
        w_levels = '0;
        for (int k = 0; k < LEVEL_COILS; k++) begin
            if (n_phase == PH_DRIVE && n_coil == COIL_W'(k)) begin
                w_levels[2*k]   = n_dir;
                w_levels[2*k+1] = ~n_dir;
            end
        end
    end

    assign o_stat.busy       = (r_phase != PH_IDLE);
    assign o_stat.busy_nxt   = (n_phase != PH_IDLE);
    assign o_stat.levels_nxt = w_levels;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_coil  <= '0;
            r_dir   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_coil  <= n_coil;
            r_dir   <= n_dir;
        end
    end

endmodule

// ===== hw/rtl/coil_command_frame_driver_core.sv =====
// ----------------------------------------------------------------------------
// Coil command frame driver
// Matches header/id/action frames in a stream of received bytes and 1 ms
// ticks, checks them, and drives a timed pulse on one coil pair.
// ----------------------------------------------------------------------------
//  Channel    Dir  Handshake     Payload
//  i_in_ch    in   valid/ready   operation, rx_byte
//  o_out_ch   out  valid/ready   coil_levels, status, frame_id, frame_action,
//                                busy_res
//  i_cfg_ch   in   valid/ready   index, data (ready is always high)
//
// Each input beat is held in an input register and resolved from there into
// the result register, so one beat is taken every cycle while results are
// taken. A result stays in the result register until it is taken. While a
// result waits, the input register still takes one more beat, and then
// i_in_ch.ready drops until the result is taken.
// Reset is synchronous and active low; config registers return to defaults.
// A stall on o_out_ch holds the pipeline and backs up to i_in_ch.ready.
// ----------------------------------------------------------------------------
module coil_command_frame_driver_core
    import ccfd_pkg::*;
#(
    parameter int COILS = COILS_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ccfd_in_if.sink     i_in_ch,
    ccfd_out_if.source  o_out_ch,
    ccfd_cfg_if.sink    i_cfg_ch
);

    // Configuration registers.
    logic [TIMEOUT_W-1:0] r_timeout;
    logic [TICK_W-1:0]    r_pause;
    logic [TICK_W-1:0]    r_drive;
    logic [BYTE_W-1:0]    r_hdr1;
    logic [BYTE_W-1:0]    r_hdr2;
    logic [BYTE_W-1:0]    r_offset;

    // Input register.
    logic                 r_in_vld;
    logic                 r_in_op;
    logic [BYTE_W-1:0]    r_in_byte;

    // Parser state.
    t_frame_pos           r_pos, n_pos;
    logic [BYTE_W-1:0]    r_id, n_id;
    logic [TIMEOUT_W-1:0] r_idle, n_idle;

    // Result register.
    logic                      r_out_vld;
    logic [LEVEL_W-1:0]        r_levels;
    t_status                   r_status, n_status;
    logic signed [FIELD_W-1:0] r_fid, n_fid;
    logic signed [FIELD_W-1:0] r_fact, n_fact;
    logic                      r_busy;

    logic                      w_step;
    logic [TIMEOUT_W-1:0]      w_idle_inc;
    logic signed [FIELD_W-1:0] w_fid;
    logic signed [FIELD_W-1:0] w_fact;
    logic                      w_bad_id;
    logic                      w_bad_act;
    t_pulse_ctl                w_ctl;
    t_pulse_stat               w_stat;

    // Handshakes.
    assign w_step          = r_in_vld && (!r_out_vld || o_out_ch.ready);
    assign i_in_ch.ready   = !r_in_vld || w_step;
    assign i_cfg_ch.ready  = 1'b1;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_pause   <= PAUSE_RST;
            r_drive   <= DRIVE_RST;
            r_hdr1    <= HDR1_RST;
            r_hdr2    <= HDR2_RST;
            r_offset  <= OFFSET_RST;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                CFG_TIMEOUT: r_timeout <= i_cfg_ch.data;
                CFG_PAUSE:   r_pause   <= i_cfg_ch.data[TICK_W-1:0];
                CFG_DRIVE:   r_drive   <= i_cfg_ch.data[TICK_W-1:0];
                CFG_HDR1:    r_hdr1    <= i_cfg_ch.data[BYTE_W-1:0];
                CFG_HDR2:    r_hdr2    <= i_cfg_ch.data[BYTE_W-1:0];
                CFG_OFFSET:  r_offset  <= i_cfg_ch.data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_vld <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_in_op   <= i_in_ch.operation;
            r_in_byte <= i_in_ch.rx_byte;
        end
    end

    // Decoded fields and their checks.
    assign w_idle_inc = (r_idle == '1) ? r_idle : r_idle + 1'b1;
    assign w_fid      = $signed({1'b0, r_id}) - $signed({1'b0, r_offset});
    assign w_fact     = $signed({1'b0, r_in_byte}) - $signed({1'b0, r_offset});
    assign w_bad_id   = w_fid[FIELD_W-1] || (w_fid[BYTE_W-1:0] >= BYTE_W'(COILS));
    assign w_bad_act  = (w_fact != FIELD_W'(0)) && (w_fact != FIELD_W'(1));

    // Frame parser.
    always_comb begin
        n_pos       = r_pos;
        n_id        = r_id;
        n_idle      = r_idle;
        n_status    = ST_NONE;
        n_fid       = '0;
        n_fact      = '0;
        w_ctl.step  = w_step;
        w_ctl.tick  = (r_in_op == OP_TICK);
        w_ctl.start = 1'b0;
        w_ctl.coil  = w_fid[COIL_W-1:0];
        w_ctl.dir   = w_fact[0];
        if (r_in_op == OP_TICK) begin
            if (r_pos != FP_HUNT) begin
                n_idle = w_idle_inc;
                if (w_idle_inc > r_timeout) begin
                    n_pos    = FP_HUNT;
                    n_status = ST_TIMEOUT;
                end
            end
        end else begin
            n_idle = '0;
            case (r_pos)
                FP_HUNT: begin
                    if (r_in_byte == r_hdr1) n_pos = FP_HDR1;
                end
                FP_HDR1: begin
                    if (r_in_byte == r_hdr2)      n_pos = FP_HDR2;
                    else if (r_in_byte == r_hdr1) n_pos = FP_HDR1;
                    else                          n_pos = FP_HUNT;
                end
                FP_HDR2: begin
                    n_id  = r_in_byte;
                    n_pos = FP_ID;
                end
                default: begin
                    n_fid  = w_fid;
                    n_fact = w_fact;
                    n_pos  = FP_HUNT;
                    if (w_bad_id) begin
                        n_status = ST_BAD_ID;
                    end else if (w_bad_act) begin
                        n_status = ST_BAD_ACTION;
                    end else if (w_stat.busy) begin
                        n_status = ST_BUSY_DROP;
                    end else begin
                        n_status    = ST_ACCEPTED;
                        w_ctl.start = 1'b1;
                    end
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= FP_HUNT;
            r_id   <= '0;
            r_idle <= '0;
        end else if (w_step) begin
            r_pos  <= n_pos;
            r_id   <= n_id;
            r_idle <= n_idle;
        end
    end

    ccfd_pulse u_pulse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_pause_ticks (r_pause),
        .i_drive_ticks (r_drive),
        .o_stat        (w_stat)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step) begin
            r_out_vld <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_levels <= w_stat.levels_nxt;
            r_status <= n_status;
            r_fid    <= n_fid;
            r_fact   <= n_fact;
            r_busy   <= w_stat.busy_nxt;
        end
    end

    assign o_out_ch.valid        = r_out_vld;
    assign o_out_ch.coil_levels  = r_levels;
    assign o_out_ch.status       = r_status;
    assign o_out_ch.frame_id     = r_fid;
    assign o_out_ch.frame_action = r_fact;
    assign o_out_ch.busy_res     = r_busy;

endmodule

// ===== hw/rtl/ccfd_checker.sv =====
// ----------------------------------------------------------------------------
// Coil command frame driver checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ccfd_checker
    import ccfd_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [LEVEL_W-1:0]        i_coil_levels,
    input logic [STATUS_W-1:0]       i_status,
    input logic signed [FIELD_W-1:0] i_frame_id,
    input logic signed [FIELD_W-1:0] i_frame_action,
    input logic                      i_busy_res
);

    // A stalled result beat holds its levels, status and frame id.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_coil_levels)
            && $stable(i_status) && $stable(i_frame_id))
        else $error("result beat changed while stalled");

    // At most one coil line is ever high.
    a_one_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $onehot0(i_coil_levels))
        else $error("more than one coil line high");

    // A driven line means a pulse is running.
    a_line_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_coil_levels != '0) |-> i_busy_res)
        else $error("coil line high while idle");

    // An accepted frame always leaves a pulse running.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_ACCEPTED) |-> i_busy_res)
        else $error("accepted frame without a pulse");

    // Beats that end no frame carry zero fields.
    a_no_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_status == ST_NONE) || (i_status == ST_TIMEOUT))
            |-> (i_frame_id == '0) && (i_frame_action == '0))
        else $error("frame fields set without a frame");

endmodule

bind coil_command_frame_driver_core ccfd_checker u_ccfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out_ch.valid),
    .i_out_ready    (o_out_ch.ready),
    .i_coil_levels  (o_out_ch.coil_levels),
    .i_status       (o_out_ch.status),
    .i_frame_id     (o_out_ch.frame_id),
    .i_frame_action (o_out_ch.frame_action),
    .i_busy_res     (o_out_ch.busy_res)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coil command frame driver testbench
// Streams received bytes and millisecond ticks into the core and checks
// every result beat against an in-bench model of the frame parser and pulse
// sequencer. A directed opening covers the field extremes and the corner
// cases. Random phases then follow, each with new register settings and a
// mix of good frames, bad frames, repeated headers, broken frames and
// timeouts. Both channels idle in random bursts except near the end.
// ----------------------------------------------------------------------------
module tb;
    import ccfd_pkg::*;

    localparam int COILS_N       = COILS_DEF;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 110;
    localparam int TAIL_ITEMS    = 150;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STUCK_LIMIT   = 1000;

    // Register indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // Kinds of entries in the stimulus stream.
    typedef enum logic [1:0] {
        K_ITEM,
        K_REG,
        K_SETTLE
    } t_stim_kind;

    typedef struct packed {
        t_stim_kind           kind;
        t_op                  op;
        logic [BYTE_W-1:0]    rx;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
    } t_stim;

    typedef struct packed {
        logic [LEVEL_W-1:0]        levels;
        t_status                   status;
        logic signed [FIELD_W-1:0] fid;
        logic signed [FIELD_W-1:0] fact;
        logic                      busy;
    } t_coil_update;

    logic clk = 1'b0;
    logic rst_n;

    ccfd_in_if  in_ch ();
    ccfd_out_if out_ch ();
    ccfd_cfg_if cfg_ch ();

    coil_command_frame_driver_core DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    t_stim        rx_stream[$];
    t_coil_update coil_updates[$];

    int  mismatches   = 0;
    int  phase_items  = 0;
    int  settle_cnt   = 0;
    int  issued       = 0;
    int  idle_level   = 0;
    int  gap_left     = 0;
    int  stall_left   = 0;
    int  stuck_cycles = 0;
    bit  in_taken     = 1'b0;
    bit  cfg_taken    = 1'b0;

    // Register values the stimulus builder expects to be in effect.
    logic [TIMEOUT_W-1:0] plan_timeout = TIMEOUT_RST;
    logic [BYTE_W-1:0]    plan_hdr1    = HDR1_RST;
    logic [BYTE_W-1:0]    plan_hdr2    = HDR2_RST;
    logic [BYTE_W-1:0]    plan_off     = OFFSET_RST;
    logic [TICK_W-1:0]    plan_pause   = PAUSE_RST;
    logic [TICK_W-1:0]    plan_drive   = DRIVE_RST;

    // Model registers and state.
    logic [TIMEOUT_W-1:0] reg_timeout = TIMEOUT_RST;
    logic [TICK_W-1:0]    reg_pause   = PAUSE_RST;
    logic [TICK_W-1:0]    reg_drive   = DRIVE_RST;
    logic [BYTE_W-1:0]    reg_hdr1    = HDR1_RST;
    logic [BYTE_W-1:0]    reg_hdr2    = HDR2_RST;
    logic [BYTE_W-1:0]    reg_offset  = OFFSET_RST;

    t_frame_pos           hunt_pos    = FP_HUNT;
    logic [BYTE_W-1:0]    held_id     = '0;
    logic [TIMEOUT_W-1:0] quiet_ticks = '0;
    t_phase               pulse       = PH_IDLE;
    logic [TICK_W-1:0]    phase_cnt   = '0;
    logic [COIL_W-1:0]    pulse_coil  = '0;
    logic                 pulse_dir   = 1'b0;

    // Clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register write as the core applies it.
    function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_TIMEOUT: reg_timeout = data[TIMEOUT_W-1:0];
            CFG_PAUSE:   reg_pause   = data[TICK_W-1:0];
            CFG_DRIVE:   reg_drive   = data[TICK_W-1:0];
            CFG_HDR1:    reg_hdr1    = data[BYTE_W-1:0];
            CFG_HDR2:    reg_hdr2    = data[BYTE_W-1:0];
            CFG_OFFSET:  reg_offset  = data[BYTE_W-1:0];
            default: ;
        endcase
    endfunction

    // One tick of the pulse sequencer.
    function automatic void advance_pulse();
        case (pulse)
            PH_PAUSE: begin
                phase_cnt++;
                if (phase_cnt >= reg_pause) begin
                    pulse     = PH_DRIVE;
                    phase_cnt = '0;
                end
            end
            PH_DRIVE: begin
                phase_cnt++;
                if (phase_cnt >= reg_drive) begin
                    pulse     = PH_IDLE;
                    phase_cnt = '0;
                end
            end
            default: begin
                pulse     = PH_IDLE;
                phase_cnt = '0;
            end
        endcase
    endfunction

    // Works out the coil update caused by one input beat.
    function automatic t_coil_update predict_coil_update(t_op op, logic [BYTE_W-1:0] rx);
        t_coil_update res;
        int           fid;
        int           fact;
        fid        = 0;
        fact       = 0;
        res        = '0;
        res.status = ST_NONE;
        if (op == OP_TICK) begin
            // Only a partial frame ages; the count saturates.
            if (hunt_pos != FP_HUNT) begin
                if (quiet_ticks != '1)
                    quiet_ticks++;
                if (quiet_ticks > reg_timeout) begin
                    hunt_pos   = FP_HUNT;
                    res.status = ST_TIMEOUT;
                end
            end
            advance_pulse();
        end else begin
            quiet_ticks = '0;
            case (hunt_pos)
                FP_HUNT: begin
                    if (rx == reg_hdr1)
                        hunt_pos = FP_HDR1;
                end
                FP_HDR1: begin
                    if (rx == reg_hdr2)
                        hunt_pos = FP_HDR2;
                    else if (rx != reg_hdr1)
                        hunt_pos = FP_HUNT;
                end
                FP_HDR2: begin
                    held_id  = rx;
                    hunt_pos = FP_ID;
                end
                default: begin
                    fid  = int'(held_id) - int'(reg_offset);
                    fact = int'(rx) - int'(reg_offset);
                    if (fid < 0 || fid >= COILS_N) begin
                        res.status = ST_BAD_ID;
                    end else if (fact != 0 && fact != 1) begin
                        res.status = ST_BAD_ACTION;
                    end else if (pulse != PH_IDLE) begin
                        res.status = ST_BUSY_DROP;
                    end else begin
                        res.status = ST_ACCEPTED;
                        pulse_coil = COIL_W'(fid);
                        pulse_dir  = fact[0];
                        phase_cnt  = '0;
                        pulse      = (reg_pause == '0) ? PH_DRIVE : PH_PAUSE;
                    end
                    hunt_pos = FP_HUNT;
                end
            endcase
        end
        if (pulse == PH_DRIVE)
            res.levels[int'(pulse_coil) * 2 + (pulse_dir ? 0 : 1)] = 1'b1;
        res.fid  = FIELD_W'(fid);
        res.fact = FIELD_W'(fact);
        res.busy = (pulse != PH_IDLE);
        return res;
    endfunction

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Stimulus builders.
    task automatic put_item(t_op op, logic [BYTE_W-1:0] rx);
        t_stim s;
        s      = '0;
        s.kind = K_ITEM;
        s.op   = op;
        s.rx   = rx;
        rx_stream.push_back(s);
        phase_items++;
    endtask

    task automatic put_byte(logic [BYTE_W-1:0] rx);
        put_item(OP_BYTE, rx);
    endtask

    // The byte carried with a tick is ignored, so it is random.
    task automatic put_ticks(int n);
        repeat (n) put_item(OP_TICK, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic put_frame(logic [BYTE_W-1:0] id, logic [BYTE_W-1:0] act);
        put_byte(plan_hdr1);
        put_byte(plan_hdr2);
        put_byte(id);
        put_byte(act);
    endtask

    task automatic put_settle();
        t_stim s;
        s      = '0;
        s.kind = K_SETTLE;
        rx_stream.push_back(s);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        t_stim s;
        s      = '0;
        s.kind = K_REG;
        s.idx  = idx;
        s.data = data;
        rx_stream.push_back(s);
        case (idx)
            CFG_TIMEOUT: plan_timeout = data[TIMEOUT_W-1:0];
            CFG_PAUSE:   plan_pause   = data[TICK_W-1:0];
            CFG_DRIVE:   plan_drive   = data[TICK_W-1:0];
            CFG_HDR1:    plan_hdr1    = data[BYTE_W-1:0];
            CFG_HDR2:    plan_hdr2    = data[BYTE_W-1:0];
            CFG_OFFSET:  plan_off     = data[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    // An 8-bit register value with random junk in the unused data bits.
    function automatic logic [CFG_DAT_W-1:0] pad8(int value);
        return {2'($urandom_range(0, 3)), BYTE_W'(value)};
    endfunction

    function automatic logic [BYTE_W-1:0] good_id();
        return BYTE_W'(plan_off + $urandom_range(0, COILS_N - 1));
    endfunction

    function automatic logic [BYTE_W-1:0] good_action();
        return BYTE_W'(plan_off + $urandom_range(0, 1));
    endfunction

    // Input and register driver: presents the next beat at the falling edge.
    always @(negedge clk) begin
        t_stim head;
        logic  send_in;
        logic  send_cfg;
        logic  load_in;
        logic  load_cfg;
        head     = '0;
        send_in  = in_ch.valid && !in_taken;
        send_cfg = cfg_ch.valid && !cfg_taken;
        load_in  = 1'b0;
        load_cfg = 1'b0;
        if (coil_updates.size() == 0 && !send_in)
            settle_cnt++;
        else
            settle_cnt = 0;
        if (rst_n && !send_in && !send_cfg && rx_stream.size() != 0) begin
            head = rx_stream[0];
            case (head.kind)
                K_ITEM: begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end else begin
                        load_in = 1'b1;
                        void'(rx_stream.pop_front());
                        issued++;
                        if (rx_stream.size() < TAIL_ITEMS)
                            idle_level = 0;
                        else if (issued % 64 == 0)
                            idle_level = $urandom_range(0, 3);
                        if (idle_level != 0 && $urandom_range(0, 7) < idle_level)
                            gap_left = $urandom_range(1, 11);
                    end
                end
                K_REG: begin
                    if (settle_cnt >= SETTLE_CYCLES) begin
                        load_cfg = 1'b1;
                        void'(rx_stream.pop_front());
                    end
                end
                default: begin
                    if (coil_updates.size() == 0)
                        void'(rx_stream.pop_front());
                end
            endcase
        end
        in_ch.valid  <= send_in || load_in;
        cfg_ch.valid <= send_cfg || load_cfg;
        if (load_in) begin
            in_ch.operation <= head.op;
            in_ch.rx_byte   <= head.rx;
        end
        if (load_cfg) begin
            cfg_ch.index <= head.idx;
            cfg_ch.data  <= head.data;
        end
    end

    // Result side back-pressure in random bursts.
    always @(negedge clk) begin
        logic take;
        if (stall_left == 0 && idle_level != 0 && $urandom_range(0, 15) < idle_level)
            stall_left = $urandom_range(1, 11);
        take = (stall_left == 0);
        if (stall_left != 0)
            stall_left--;
        out_ch.ready <= take;
    end

    // Monitor: checks result beats, then tracks register and input beats.
    always @(posedge clk) begin
        t_coil_update want;
        in_taken  = 1'b0;
        cfg_taken = 1'b0;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (coil_updates.size() == 0) begin
                    $error("result beat with no expected update pending");
                    mismatches++;
                end else begin
                    want = coil_updates.pop_front();
                    check_field("coil_levels", want.levels, out_ch.coil_levels);
                    check_field("status", want.status, out_ch.status);
                    check_field("frame_id", $signed(want.fid), $signed(out_ch.frame_id));
                    check_field("frame_action", $signed(want.fact),
                                $signed(out_ch.frame_action));
                    check_field("busy_res", want.busy, out_ch.busy_res);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                write_register(cfg_ch.index, cfg_ch.data);
                cfg_taken = 1'b1;
            end
            if (in_ch.valid && in_ch.ready) begin
                coil_updates.push_back(predict_coil_update(t_op'(in_ch.operation),
                                                           in_ch.rx_byte));
                in_taken = 1'b1;
            end
        end
    end

    // Watchdog on cycles where no beat moves on any channel.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus build, reset and end of run.
    initial begin
        int                   ph;
        int                   choice;
        int                   n;
        int                   span;
        int                   tmo;
        int                   pse;
        int                   drv;
        int                   h1;
        int                   h2;
        int                   off;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_BYTE;
        in_ch.rx_byte   = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_TIMEOUT;
        cfg_ch.data     = '0;
        out_ch.ready    = 1'b0;
        rst_n           = 1'b0;

        // Directed: accept, busy drop, bad id and bad action during a pulse.
        put_reg(CFG_PAUSE, 10'd2);
        put_reg(CFG_DRIVE, 10'd3);
        put_reg(CFG_TIMEOUT, 10'd3);
        put_frame(plan_off, plan_off);
        put_frame(BYTE_W'(plan_off + 8), BYTE_W'(plan_off + 1));
        put_frame(8'hFF, plan_off);
        put_frame(BYTE_W'(plan_off + 3), 8'hFF);
        put_ticks(6);
        // Repeated first header still matches, then a stray zero byte.
        put_byte(plan_hdr1);
        put_frame(BYTE_W'(plan_off + 8), BYTE_W'(plan_off + 1));
        put_byte(8'h00);

        // Pause and drive cut to zero while that pulse is still in its pause.
        put_reg(CFG_PAUSE, 10'd0);
        put_reg(CFG_DRIVE, 10'd0);
        put_reg(CFG_TIMEOUT, 10'd0);
        put_reg(CFG_SPARE_A, 10'h3FF);
        put_reg(CFG_SPARE_B, 10'h000);
        put_ticks(2);
        put_frame(BYTE_W'(plan_off + 5), plan_off);
        put_ticks(1);
        // Zero timeout discards on the first tick.
        put_byte(plan_hdr1);
        put_ticks(1);

        // A timeout of all ones holds a partial frame across a run of ticks.
        put_reg(CFG_TIMEOUT, 10'd1023);
        put_byte(plan_hdr1);
        put_ticks(40);
        put_byte(plan_hdr2);
        put_byte(BYTE_W'(plan_off + 1));
        put_byte(plan_off);

        // Random phases, each starting from a quiet core with new settings.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            tmo = $urandom_range(0, 8);
            pse = $urandom_range(0, 6);
            drv = $urandom_range(0, 6);
            h1  = $urandom_range(0, 255);
            h2  = $urandom_range(0, 255);
            off = $urandom_range(0, 255);
            case (ph)
                0: begin off = 0;   h1 = 0;   h2 = 255; tmo = 0;    end
                1: begin off = 255; h1 = 255; h2 = 0;   tmo = 1023; end
                2: begin pse = 255; drv = 255; end
                3: begin drv = 1;   h2 = h1;   end
                4: begin h1 = HDR1_RST; h2 = HDR2_RST; off = OFFSET_RST; end
                default: ;
            endcase
            put_settle();
            put_reg(CFG_TIMEOUT, CFG_DAT_W'(tmo));
            put_reg(CFG_PAUSE, pad8(pse));
            put_reg(CFG_DRIVE, pad8(drv));
            put_reg(CFG_HDR1, pad8(h1));
            put_reg(CFG_HDR2, pad8(h2));
            put_reg(CFG_OFFSET, pad8(off));
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                choice = $urandom_range(0, 99);
                if (choice < 45) begin
                    put_frame(good_id(), good_action());
                end else if (choice < 55) begin
                    put_frame(BYTE_W'($urandom_range(0, 255)), good_action());
                end else if (choice < 63) begin
                    put_frame(good_id(), BYTE_W'($urandom_range(0, 255)));
                end else if (choice < 70) begin
                    repeat ($urandom_range(1, 3)) put_byte(plan_hdr1);
                    put_frame(good_id(), good_action());
                end else if (choice < 78) begin
                    // Frame broken off after its header.
                    put_byte(plan_hdr1);
                    if ($urandom_range(0, 1) == 1)
                        put_byte(plan_hdr2);
                    else
                        put_byte(BYTE_W'($urandom_range(0, 255)));
                end else if (choice < 85) begin
                    repeat ($urandom_range(1, 4)) put_byte(BYTE_W'($urandom_range(0, 255)));
                end else begin
                    // Partial frame left to age out.
                    n = $urandom_range(1, 3);
                    put_byte(plan_hdr1);
                    if (n > 1)
                        put_byte(plan_hdr2);
                    if (n > 2)
                        put_byte(good_id());
                    put_ticks(plan_timeout <= 30 ? int'(plan_timeout) + 2 : 3);
                end
                span = int'(plan_pause) + int'(plan_drive) + 2;
                if (span > 24)
                    span = 24;
                if ($urandom_range(0, 3) == 0)
                    put_ticks($urandom_range(0, span));
                else
                    put_ticks($urandom_range(0, 2));
            end
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        while (rx_stream.size() != 0 || in_ch.valid || cfg_ch.valid)
            @(negedge clk);
        while (coil_updates.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
